// ===== hdl/fcrq_pkg.sv =====
// Package for the framed command receiver queue.
// Holds the sizes, the request kind and status codes and the ring helpers.
// Has no dependencies.
package fcrq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PARAM_MAX   = 32;
  localparam int HDR_BYTES   = 2;
  localparam int SLOT_BYTES  = PARAM_MAX + HDR_BYTES;
  localparam int MEM_DEPTH   = QUEUE_DEPTH * SLOT_BYTES;

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [1:0] KIND_RX     = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_EMPTY = 2'd0;
  localparam logic [1:0] STATUS_DATA  = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [7:0] FLAG_RESET = 8'd170;

  function automatic slot_t next_slot(input slot_t s);
    if (s == slot_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return s + slot_t'(1);
  endfunction

  function automatic logic [1:0] queue_status(input slot_t head, input slot_t tail);
    if (head == tail) begin
      return STATUS_EMPTY;
    end
    if (head == next_slot(tail)) begin
      return STATUS_FULL;
    end
    return STATUS_DATA;
  endfunction

endpackage

// ===== hdl/framed_command_receiver_queue.sv =====
// Top level of the framed command receiver queue.
// Frames are kept in one byte-wide synchronous memory; depends on fcrq_pkg.
//
// Every request is taken at once and busy stays low, so a request may be
// given in every cycle. Its result appears on the out_ ports, marked by
// out_strobe, in the cycle after the request was taken; read data comes from
// the registered read port of the frame memory. The receiver cannot
// stall, and results are never held back. Received bytes go straight into the
// tail slot of the frame memory, and a head read never touches that slot, so
// no forwarding is needed. The frame memory needs no clearing after reset.
// The start flag may be written at any time through the cfg_ channel.
module framed_command_receiver_queue
  import fcrq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic [5:0] in_read_index,
  output logic       out_strobe,
  output logic [1:0] out_queue_status,
  output logic       out_frame_stored,
  output logic       out_frame_dropped,
  output logic       out_read_valid,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam logic [7:0] PARAM_MAX_B = 8'(PARAM_MAX);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_q;

  logic [7:0] start_flag_r;
  logic       recv_r, recv_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  slot_t      head_r, head_nxt;
  slot_t      tail_r, tail_nxt;

  logic       strobe_r;
  logic [1:0] status_r;
  logic       stored_r, stored_nxt;
  logic       dropped_r, dropped_nxt;
  logic       rvalid_r, rvalid_nxt;
  logic       rhit_r, rhit_nxt;

  logic       take;
  logic       we, re;
  addr_t      waddr, raddr;
  logic       last_byte;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  assign waddr = addr_t'(tail_r) * addr_t'(SLOT_BYTES) + addr_t'(cnt_r);
  assign raddr = addr_t'(head_r) * addr_t'(SLOT_BYTES) + addr_t'(in_read_index);

  always_comb begin
    recv_nxt    = recv_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    stored_nxt  = 1'b0;
    dropped_nxt = 1'b0;
    rvalid_nxt  = 1'b0;
    rhit_nxt    = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    last_byte   = 1'b0;
    if (take) begin
      unique case (in_kind)
        KIND_RX: begin
          if (!recv_r) begin
            if (in_rx_byte == start_flag_r) begin
              recv_nxt = 1'b1;
              cnt_nxt  = '0;
            end
          end else begin
            we      = cnt_r < cnt_t'(SLOT_BYTES);
            cnt_nxt = cnt_r + cnt_t'(1);
            if (cnt_r == cnt_t'(1)) begin
              len_nxt   = in_rx_byte;
              last_byte = in_rx_byte == 8'd0;
            end else if (cnt_r > cnt_t'(1)) begin
              last_byte = {1'b0, len_r} + 9'(HDR_BYTES - 1) == 9'(cnt_r);
            end
            if (cnt_r == cnt_t'(1) && in_rx_byte > PARAM_MAX_B) begin
              dropped_nxt = 1'b1;
              recv_nxt    = 1'b0;
              cnt_nxt     = '0;
            end else if (last_byte) begin
              if (queue_status(head_r, tail_r) == STATUS_FULL) begin
                dropped_nxt = 1'b1;
              end else begin
                tail_nxt   = next_slot(tail_r);
                stored_nxt = 1'b1;
              end
              recv_nxt = 1'b0;
              cnt_nxt  = '0;
            end
          end
        end
        KIND_READ: begin
          if (queue_status(head_r, tail_r) != STATUS_EMPTY) begin
            rvalid_nxt = 1'b1;
            rhit_nxt   = in_read_index < 6'(SLOT_BYTES);
            re         = rhit_nxt;
          end
        end
        KIND_REMOVE: begin
          if (queue_status(head_r, tail_r) != STATUS_EMPTY) begin
            head_nxt = next_slot(head_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_rx_byte;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r <= FLAG_RESET;
      recv_r       <= 1'b0;
      cnt_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      strobe_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_flag_r <= cfg_data;
      end
      recv_r   <= recv_nxt;
      cnt_r    <= cnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      strobe_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    status_r  <= queue_status(head_nxt, tail_nxt);
    stored_r  <= stored_nxt;
    dropped_r <= dropped_nxt;
    rvalid_r  <= rvalid_nxt;
    rhit_r    <= rhit_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_queue_status  = status_r;
  assign out_frame_stored  = stored_r;
  assign out_frame_dropped = dropped_r;
  assign out_read_valid    = rvalid_r;
  assign out_read_data     = (rvalid_r && rhit_r) ? rd_q : 8'd0;

endmodule

// ===== sim/framed_command_receiver_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for framed_command_receiver_queue: framed byte traffic,
// head reads and removes, each result checked against a built-in queue model.
// Depends on fcrq_pkg and the framed_command_receiver_queue RTL.
module framed_command_receiver_queue_tb;
  import fcrq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CLK_HALF = 4;
  localparam int DRAIN_LIMIT = 1000;
  localparam int PHASE_ITEMS = 476;

  typedef struct packed {
    logic [1:0] queue_status;
    logic       frame_stored;
    logic       frame_dropped;
    logic       read_valid;
    logic [7:0] read_data;
  } queue_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_kind = KIND_RX;
  logic [7:0] in_rx_byte = 8'd0;
  logic [5:0] in_read_index = 6'd0;
  logic       out_strobe;
  logic [1:0] out_queue_status;
  logic       out_frame_stored;
  logic       out_frame_dropped;
  logic       out_read_valid;
  logic [7:0] out_read_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  logic [7:0]    flag_value = FLAG_RESET;
  bit            rx_active;
  int            rx_count;
  logic [7:0]    frame_mem [MEM_DEPTH];
  bit            mem_written [MEM_DEPTH];
  int            head_ptr;
  int            tail_ptr;
  queue_result_t expected_results [$];
  int            error_count = 0;
  int            items_sent = 0;
  int            send_idle_pct = 0;

  framed_command_receiver_queue uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .in_read_index     (in_read_index),
    .out_strobe        (out_strobe),
    .out_queue_status  (out_queue_status),
    .out_frame_stored  (out_frame_stored),
    .out_frame_dropped (out_frame_dropped),
    .out_read_valid    (out_read_valid),
    .out_read_data     (out_read_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  initial begin
    #2_000_000;
    $display("framed_command_receiver_queue verification failed");
    $finish;
  end

  function automatic logic [1:0] ring_status();
    int held;
    held = (tail_ptr - head_ptr + QUEUE_DEPTH) % QUEUE_DEPTH;
    if (held == 0) begin
      return STATUS_EMPTY;
    end
    if (held == QUEUE_DEPTH - 1) begin
      return STATUS_FULL;
    end
    return STATUS_DATA;
  endfunction

  function automatic queue_result_t predict_request(input logic [1:0] kind,
                                                    input logic [7:0] rx,
                                                    input logic [5:0] idx);
    queue_result_t r;
    int base;
    int len;
    r = '0;
    base = tail_ptr * SLOT_BYTES;
    case (kind)
      KIND_RX: begin
        if (!rx_active) begin
          if (rx == flag_value) begin
            rx_active = 1'b1;
            rx_count = 0;
          end
        end else begin
          if (rx_count < SLOT_BYTES) begin
            frame_mem[base + rx_count] = rx;
            mem_written[base + rx_count] = 1'b1;
          end
          rx_count++;
          if (rx_count == HDR_BYTES && rx > PARAM_MAX) begin
            r.frame_dropped = 1'b1;
            rx_active = 1'b0;
            rx_count = 0;
          end else if (rx_count >= HDR_BYTES) begin
            len = frame_mem[base + 1];
            if (rx_count >= len + HDR_BYTES) begin
              if (ring_status() == STATUS_FULL) begin
                r.frame_dropped = 1'b1;
              end else begin
                tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
                r.frame_stored = 1'b1;
              end
              rx_active = 1'b0;
              rx_count = 0;
            end
          end
        end
      end
      KIND_READ: begin
        if (ring_status() != STATUS_EMPTY) begin
          r.read_valid = 1'b1;
          if (idx < SLOT_BYTES) begin
            r.read_data = frame_mem[head_ptr * SLOT_BYTES + idx];
          end
        end
      end
      KIND_REMOVE: begin
        if (ring_status() != STATUS_EMPTY) begin
          head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
        end
      end
      default: begin
      end
    endcase
    r.queue_status = ring_status();
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: queue_status %0d", out_queue_status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("queue_status", want.queue_status, out_queue_status);
        check_field("frame_stored", want.frame_stored, out_frame_stored);
        check_field("frame_dropped", want.frame_dropped, out_frame_dropped);
        check_field("read_valid", want.read_valid, out_read_valid);
        check_field("read_data", want.read_data, out_read_data);
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [7:0] rx,
                              input logic [5:0] idx);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= rx;
    in_read_index <= idx;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_request(kind, rx, idx));
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input int param_count);
    send_request(KIND_RX, flag_value, 6'($urandom));
    send_request(KIND_RX, cmd, 6'($urandom));
    send_request(KIND_RX, len, 6'($urandom));
    repeat (param_count) send_request(KIND_RX, 8'($urandom), 6'($urandom));
  endtask

  task automatic wait_results_drained();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_start_flag(input logic [7:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    flag_value = value;
  endtask

  task automatic test_empty_queue_requests();
    send_request(KIND_READ, 8'd0, 6'd0);
    send_request(KIND_REMOVE, 8'd0, 6'd0);
    send_request(KIND_UNUSED, 8'hFF, 6'h3F);
    send_request(KIND_RX, 8'h55, 6'd0);
  endtask

  task automatic test_frame_handling();
    send_frame(8'hFF, 8'd0, 0);
    send_frame(8'h00, 8'(PARAM_MAX + 1), 0);
    // The flag value inside a frame is ordinary parameter data.
    send_frame(8'h12, 8'd2, 0);
    send_request(KIND_RX, flag_value, 6'd0);
    send_request(KIND_RX, 8'h00, 6'd0);
    send_request(KIND_READ, 8'd0, 6'd0);
    send_request(KIND_READ, 8'd0, 6'd1);
    send_request(KIND_READ, 8'd0, 6'(SLOT_BYTES));
    send_request(KIND_READ, 8'd0, 6'h3F);
    send_request(KIND_REMOVE, 8'd0, 6'd0);
    send_request(KIND_READ, 8'd0, 6'd3);
    send_request(KIND_REMOVE, 8'd0, 6'd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int item_goal);
    int sent_before;
    int pick;
    int len;
    int idx;
    int base;
    send_idle_pct = idle_pct;
    sent_before = items_sent;
    while (items_sent - sent_before < item_goal) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) begin
        len = PARAM_MAX;
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(PARAM_MAX, 9);
      end else begin
        len = $urandom_range(8, 0);
      end
      if (pick < 30) begin
        send_frame(8'($urandom), 8'(len), len);
      end else if (pick < 37) begin
        send_frame(8'($urandom), 8'(len), $urandom_range(len, 0));
      end else if (pick < 40) begin
        send_frame(8'($urandom), 8'($urandom_range(255, PARAM_MAX + 1)), 0);
      end else if (pick < 62) begin
        // Only entries of the head slot that were written are ever read.
        base = head_ptr * SLOT_BYTES;
        if ($urandom_range(99) < 12) begin
          idx = $urandom_range(63, SLOT_BYTES);
        end else begin
          idx = $urandom_range(SLOT_BYTES - 1, 0);
          if (ring_status() != STATUS_EMPTY && !mem_written[base + idx]) begin
            idx = $urandom_range(frame_mem[base + 1] + 1, 0);
          end
        end
        send_request(KIND_READ, 8'($urandom), 6'(idx));
      end else if (pick < 92) begin
        send_request(KIND_REMOVE, 8'($urandom), 6'($urandom));
      end else if (pick < 96) begin
        send_request(KIND_RX, 8'($urandom), 6'($urandom));
      end else if (pick < 99) begin
        send_request(KIND_UNUSED, 8'($urandom), 6'($urandom));
      end else begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue_requests();
    test_frame_handling();
    write_start_flag(8'h00);
    test_random_traffic(20, PHASE_ITEMS);
    write_start_flag(8'hFF);
    test_random_traffic(47, PHASE_ITEMS);
    write_start_flag(8'($urandom_range(254, 1)));
    test_random_traffic(0, PHASE_ITEMS);
    wait_results_drained();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("framed_command_receiver_queue verification clean");
    end else begin
      $display("framed_command_receiver_queue verification failed");
    end
    $finish;
  end

endmodule
